>>> src/rc_reflectance_line_sensor_timer_defines.svh
// Assertion macros for the reflectance line sensor timer.
// Relies on i_clk and i_rst_n in the module that includes it.
`ifndef RC_REFLECTANCE_LINE_SENSOR_TIMER_DEFINES_SVH
`define RC_REFLECTANCE_LINE_SENSOR_TIMER_DEFINES_SVH

// same-cycle implication
`define RCLST_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("rclst: same-cycle check failed");

// next-cycle implication
`define RCLST_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("rclst: next-cycle check failed");

`endif

>>> src/rclst_pkg.sv
// Shared constants and types for the reflectance line sensor timer.
// No dependencies.
package rclst_pkg;

    localparam int NUM_SENSORS = 5;
    localparam int TIME_BITS   = 12;
    localparam int GRAY_W      = 7;
    localparam int IDX_W       = 3;
    localparam int SEL_W       = $clog2(NUM_SENSORS);
    localparam int CFG_W       = NUM_SENSORS * TIME_BITS;
    localparam int REM_W       = TIME_BITS + GRAY_W;
    localparam int CNT_W       = $clog2(GRAY_W);

    localparam logic [TIME_BITS-1:0]   TIME_MAX  = {TIME_BITS{1'b1}};
    localparam logic [GRAY_W-1:0]      GRAY_FULL = GRAY_W'(100);
    localparam logic [NUM_SENSORS-1:0] ALL_SENS  = {NUM_SENSORS{1'b1}};

    localparam logic CFG_BLANK  = 1'b0;
    localparam logic CFG_BLACK  = 1'b1;
    localparam logic KIND_TICK  = 1'b0;
    localparam logic KIND_START = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SETUP,
        S_DIV,
        S_STORE,
        S_EMIT
    } t_state;

endpackage

>>> src/rc_reflectance_line_sensor_timer.sv
// Reflectance line sensor timer: RC discharge capture and grey level conversion.
// Depends on rclst_pkg and rc_reflectance_line_sensor_timer_defines.svh.
//
// channel | direction | handshake          | payload
// in      | sink      | i_valid / o_stall  | i_kind, i_levels
// out     | source    | o_valid / i_stall  | o_gray_0..4, o_black_mask, o_max_index, o_all_blank
// cfg     | sink      | i_cfg_we           | i_cfg_idx, i_cfg_data
//
// Start and tick beats are accepted only in the idle state.
// The tick that captures the last sensor starts the grey conversion: per sensor a
// setup step, the shared restoring divider when needed, and a store step; then an
// emit step. The input stays stalled from that tick beat until the result is emitted.
// The emit step waits while i_stall holds a previous result in the output register.
// Synchronous active-low reset clears the timer, pending mask and thresholds.
`include "rc_reflectance_line_sensor_timer_defines.svh"

module rc_reflectance_line_sensor_timer
    import rclst_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_stall,
    input  logic                   i_kind,
    input  logic [NUM_SENSORS-1:0] i_levels,
    output logic                   o_valid,
    input  logic                   i_stall,
    output logic [GRAY_W-1:0]      o_gray_0,
    output logic [GRAY_W-1:0]      o_gray_1,
    output logic [GRAY_W-1:0]      o_gray_2,
    output logic [GRAY_W-1:0]      o_gray_3,
    output logic [GRAY_W-1:0]      o_gray_4,
    output logic [NUM_SENSORS-1:0] o_black_mask,
    output logic [IDX_W-1:0]       o_max_index,
    output logic                   o_all_blank,
    input  logic                   i_cfg_we,
    input  logic                   i_cfg_idx,
    input  logic [CFG_W-1:0]       i_cfg_data
);

    t_state                 r_state, n_state;
    logic [CFG_W-1:0]       r_blank, n_blank;
    logic [CFG_W-1:0]       r_black, n_black;
    logic [TIME_BITS-1:0]   r_elapsed, n_elapsed;
    logic [NUM_SENSORS-1:0] r_pend, n_pend;
    logic [TIME_BITS-1:0]   r_longest, n_longest;
    logic [IDX_W-1:0]       r_long_idx, n_long_idx;
    logic                   r_out_valid, n_out_valid;
    logic [SEL_W-1:0]       r_sel, n_sel;
    logic [CNT_W-1:0]       r_cnt, n_cnt;

    logic [TIME_BITS-1:0]   r_time [NUM_SENSORS];
    logic [TIME_BITS-1:0]   n_time [NUM_SENSORS];
    logic [GRAY_W-1:0]      r_gray [NUM_SENSORS];
    logic [GRAY_W-1:0]      n_gray [NUM_SENSORS];
    logic [GRAY_W-1:0]      r_o_gray [NUM_SENSORS];
    logic [GRAY_W-1:0]      n_o_gray [NUM_SENSORS];
    logic [NUM_SENSORS-1:0] r_mask, n_mask;
    logic [NUM_SENSORS-1:0] r_o_mask, n_o_mask;
    logic [IDX_W-1:0]       r_o_idx, n_o_idx;
    logic                   r_o_blank, n_o_blank;
    logic [REM_W-1:0]       r_rem, n_rem;
    logic [REM_W-1:0]       r_dsh, n_dsh;
    logic [GRAY_W-1:0]      r_q, n_q;

    logic                   in_go;
    logic                   emit_go;
    logic [NUM_SENSORS-1:0] cap;
    logic [IDX_W-1:0]       cap_first;
    logic [TIME_BITS-1:0]   cur_t, cur_bl, cur_bk, diff, den;
    logic [REM_W-1:0]       diff_x;
    logic                   ge;
    logic                   any_gray;

    assign o_stall = (r_state != S_IDLE);
    assign in_go   = i_valid && !o_stall;
    assign emit_go = (r_state == S_EMIT) && (!r_out_valid || !i_stall);

    assign cur_t  = r_time[r_sel];
    assign cur_bl = r_blank[r_sel*TIME_BITS +: TIME_BITS];
    assign cur_bk = r_black[r_sel*TIME_BITS +: TIME_BITS];
    assign diff   = cur_t - cur_bl;
    assign den    = cur_bk - cur_bl;
    assign diff_x = REM_W'(diff);
    assign ge     = (r_rem >= r_dsh);

    always_comb begin
        cap       = '0;
        cap_first = '0;
        any_gray  = 1'b0;
        n_state     = r_state;
        n_blank     = r_blank;
        n_black     = r_black;
        n_elapsed   = r_elapsed;
        n_pend      = r_pend;
        n_longest   = r_longest;
        n_long_idx  = r_long_idx;
        n_out_valid = r_out_valid;
        n_sel       = r_sel;
        n_cnt       = r_cnt;
        n_time      = r_time;
        n_gray      = r_gray;
        n_o_gray    = r_o_gray;
        n_mask      = r_mask;
        n_o_mask    = r_o_mask;
        n_o_idx     = r_o_idx;
        n_o_blank   = r_o_blank;
        n_rem       = r_rem;
        n_dsh       = r_dsh;
        n_q         = r_q;

        if (i_cfg_we) begin
            if (i_cfg_idx == CFG_BLANK) begin
                n_blank = i_cfg_data;
            end else begin
                n_black = i_cfg_data;
            end
        end

        if (r_out_valid && !i_stall) begin
            n_out_valid = 1'b0;
        end

        for (int i = 0; i < NUM_SENSORS; i++) begin
            if (r_gray[i] != '0) begin
                any_gray = 1'b1;
            end
        end

        case (r_state)
            S_IDLE: begin
                if (in_go) begin
                    if (i_kind == KIND_START) begin
                        n_elapsed = '0;
                        n_pend    = ALL_SENS;
                        n_longest = '0;
                    end else if (r_pend != '0) begin
                        cap = r_pend & (~i_levels | {NUM_SENSORS{r_elapsed == TIME_MAX}});
                        for (int i = NUM_SENSORS - 1; i >= 0; i--) begin
                            if (cap[i]) begin
                                n_time[i] = r_elapsed;
                                cap_first = IDX_W'(i);
                            end
                        end
                        if (cap != '0 && r_elapsed > r_longest) begin
                            n_longest  = r_elapsed;
                            n_long_idx = cap_first;
                        end
                        if (r_elapsed != TIME_MAX) begin
                            n_elapsed = r_elapsed + 1'b1;
                        end
                        n_pend = r_pend & ~cap;
                        if ((r_pend & ~cap) == '0) begin
                            n_state = S_SETUP;
                            n_sel   = '0;
                            n_mask  = '0;
                        end
                    end
                end
            end
            S_SETUP: begin
                if (cur_t > cur_bk) begin
                    n_q           = GRAY_FULL;
                    n_mask[r_sel] = 1'b1;
                    n_state       = S_STORE;
                end else if (cur_bl > cur_t || cur_bk == cur_bl) begin
                    n_q     = '0;
                    n_state = S_STORE;
                end else begin
                    // rem = 100 * (t - blank), divisor aligned to the top quotient bit
                    n_rem   = (diff_x << 6) + (diff_x << 5) + (diff_x << 2);
                    n_dsh   = REM_W'(den) << (GRAY_W - 1);
                    n_q     = '0;
                    n_cnt   = '0;
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                if (ge) begin
                    n_rem = r_rem - r_dsh;
                end
                n_q   = {r_q[GRAY_W-2:0], ge};
                n_dsh = r_dsh >> 1;
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(GRAY_W - 1)) begin
                    n_state = S_STORE;
                end
            end
            S_STORE: begin
                n_gray[r_sel] = r_q;
                if (r_sel == SEL_W'(NUM_SENSORS - 1)) begin
                    n_state = S_EMIT;
                end else begin
                    n_sel   = r_sel + 1'b1;
                    n_state = S_SETUP;
                end
            end
            S_EMIT: begin
                if (emit_go) begin
                    n_o_gray    = r_gray;
                    n_o_mask    = r_mask;
                    n_o_idx     = r_long_idx;
                    n_o_blank   = !any_gray;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_blank     <= '0;
            r_black     <= '0;
            r_elapsed   <= '0;
            r_pend      <= '0;
            r_longest   <= '0;
            r_long_idx  <= '0;
            r_out_valid <= 1'b0;
            r_sel       <= '0;
            r_cnt       <= '0;
        end else begin
            r_state     <= n_state;
            r_blank     <= n_blank;
            r_black     <= n_black;
            r_elapsed   <= n_elapsed;
            r_pend      <= n_pend;
            r_longest   <= n_longest;
            r_long_idx  <= n_long_idx;
            r_out_valid <= n_out_valid;
            r_sel       <= n_sel;
            r_cnt       <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_time    <= n_time;
        r_gray    <= n_gray;
        r_o_gray  <= n_o_gray;
        r_mask    <= n_mask;
        r_o_mask  <= n_o_mask;
        r_o_idx   <= n_o_idx;
        r_o_blank <= n_o_blank;
        r_rem     <= n_rem;
        r_dsh     <= n_dsh;
        r_q       <= n_q;
    end

    assign o_valid      = r_out_valid;
    assign o_gray_0     = r_o_gray[0];
    assign o_gray_1     = r_o_gray[1];
    assign o_gray_2     = r_o_gray[2];
    assign o_gray_3     = r_o_gray[3];
    assign o_gray_4     = r_o_gray[4];
    assign o_black_mask = r_o_mask;
    assign o_max_index  = r_o_idx;
    assign o_all_blank  = r_o_blank;

    `RCLST_ASSERT_NOW(a_busy_none_pending, r_state != S_IDLE, r_pend == '0)
    `RCLST_ASSERT_NOW(a_quot_in_range, r_state == S_STORE, r_q <= GRAY_FULL)
    `RCLST_ASSERT_NEXT(a_emit_shows_beat, emit_go, o_valid && r_state == S_IDLE)
    `RCLST_ASSERT_NEXT(a_div_ends_in_store, r_state == S_DIV && r_cnt == CNT_W'(GRAY_W - 1), r_state == S_STORE)

endmodule
